FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lcdnw_pkg.sv
// types, constants and microcode table of the lcd nibble write sequencer
`timescale 1ns / 1ps
package lcdnw_pkg;

	localparam int MODE_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int NIB_W   = 4;
	localparam int TPU_W   = 7;
	localparam int HOLD_W  = 19;
	localparam int US_W    = 13;
	localparam int PROD_W  = US_W + TPU_W;
	localparam int PC_W    = 4;
	localparam int SUB_W   = 3;

	localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(3);

	// pin states within one byte: three for the high nibble, three for the low
	localparam logic [SUB_W-1:0] SUB_HI_TAIL = SUB_W'(2);
	localparam logic [SUB_W-1:0] SUB_E_HI_LO = SUB_W'(4);
	localparam logic [SUB_W-1:0] SUB_LO_TAIL = SUB_W'(5);
	localparam logic [SUB_W-1:0] SUB_E_HI_HI = SUB_W'(1);

	localparam logic [US_W-1:0] US_STROBE   = US_W'(6);
	localparam logic [US_W-1:0] US_CMD      = US_W'(40);
	localparam logic [US_W-1:0] US_DATA     = US_W'(1600);
	localparam logic [US_W-1:0] US_BYTE_END = US_W'(1000);
	localparam logic [US_W-1:0] US_WAKE_1   = US_W'(5000);
	localparam logic [US_W-1:0] US_WAKE_2   = US_W'(160);

	localparam logic [PC_W-1:0] PC_LAST = PC_W'(11);

	typedef enum logic [MODE_W-1:0] {
		MODE_CMD   = 2'd0,
		MODE_DATA  = 2'd1,
		MODE_INIT  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EXTRA_NONE = 2'd0,
		EXTRA_160  = 2'd1,
		EXTRA_5000 = 2'd2
	} extra_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	// one control word per byte of a run
	typedef struct packed {
		logic              use_input;
		logic [BYTE_W-1:0] const_byte;
		logic              rs;
		extra_t            extra;
		logic              end_run;
	} ucw_t;

	// sequencer to datapath: the pin state to emit this cycle
	typedef struct packed {
		logic              go;
		logic [BYTE_W-1:0] byte_val;
		logic              rs;
		extra_t            extra;
		logic              end_run;
		logic [SUB_W-1:0]  sub;
	} step_t;

	function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
		ucw_t w;
		w = '{use_input: 1'b0, const_byte: 8'h00, rs: 1'b0, extra: EXTRA_NONE,
			end_run: 1'b1};
		case (pc)
			4'd0: begin w.use_input = 1'b1; end
			4'd1: begin w.use_input = 1'b1; w.rs = 1'b1; end
			4'd2: begin w.const_byte = 8'h30; w.extra = EXTRA_5000; w.end_run = 1'b0; end
			4'd3: begin w.const_byte = 8'h30; w.extra = EXTRA_160; w.end_run = 1'b0; end
			4'd4: begin w.const_byte = 8'h30; w.extra = EXTRA_160; w.end_run = 1'b0; end
			4'd5: begin w.const_byte = 8'h28; w.end_run = 1'b0; end
			4'd6: begin w.const_byte = 8'h01; w.end_run = 1'b0; end
			4'd7: begin w.const_byte = 8'h80; w.end_run = 1'b0; end
			4'd8: begin w.const_byte = 8'h10; w.end_run = 1'b0; end
			4'd9: begin w.const_byte = 8'h06; end
			4'd10: begin w.const_byte = 8'h01; w.end_run = 1'b0; end
			4'd11: begin w.const_byte = 8'h80; end
			default: begin w.end_run = 1'b1; end
		endcase
		return w;
	endfunction

	function automatic logic [PC_W-1:0] ucode_entry(input mode_t m);
		logic [PC_W-1:0] pc;
		case (m)
			MODE_CMD:   pc = PC_W'(0);
			MODE_DATA:  pc = PC_W'(1);
			MODE_INIT:  pc = PC_W'(2);
			MODE_CLEAR: pc = PC_W'(10);
			default:    pc = PC_W'(0);
		endcase
		return pc;
	endfunction

endpackage

FILE: rtl/core/lcdnw_if.sv
// request and pin-state channel interfaces
`timescale 1ns / 1ps
interface lcdnw_req_if import lcdnw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] byte_value;

	modport source(output valid, mode, byte_value, input ready);
	modport sink(input valid, mode, byte_value, output ready);
endinterface

interface lcdnw_pin_if import lcdnw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NIB_W-1:0]  data_nibble;
	logic              register_select;
	logic              enable_pin;
	logic [HOLD_W-1:0] hold_ticks;
	logic              last;

	modport source(output valid, data_nibble, register_select, enable_pin, hold_ticks, last,
		input ready);
	modport sink(input valid, data_nibble, register_select, enable_pin, hold_ticks, last,
		output ready);
endinterface

FILE: rtl/core/lcdnw_useq.sv
// microcode sequencer: program counter, pin-state counter and entry jumps
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcdnw_useq import lcdnw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [MODE_W-1:0] req_mode,
	input  logic [BYTE_W-1:0] req_byte,
	input  logic              adv,
	output step_t             step
);

	seq_state_t        state_q;
	logic [PC_W-1:0]   pc_q;
	logic [SUB_W-1:0]  sub_q;
	logic [BYTE_W-1:0] byte_q;
	ucw_t              cw;
	logic              fire;
	logic              byte_done;

	assign cw        = ucode_rom(pc_q);
	assign req_ready = (state_q == ST_IDLE);
	assign fire      = (state_q == ST_RUN) && adv;
	assign byte_done = fire && (sub_q == SUB_LO_TAIL);

	assign step.go       = (state_q == ST_RUN);
	assign step.byte_val = cw.use_input ? byte_q : cw.const_byte;
	assign step.rs       = cw.rs;
	assign step.extra    = cw.extra;
	assign step.end_run  = cw.end_run;
	assign step.sub      = sub_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			sub_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_RUN;
						pc_q    <= ucode_entry(mode_t'(req_mode));
						sub_q   <= '0;
					end
				end
				ST_RUN: begin
					if (byte_done) begin
						sub_q <= '0;
						// conditional jump: end of program returns to idle
						if (cw.end_run) begin
							state_q <= ST_IDLE;
						end else begin
							pc_q <= pc_q + PC_W'(1);
						end
					end else if (fire) begin
						sub_q <= sub_q + SUB_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			byte_q <= req_byte;
		end
	end

	`ASSERT_IMP(a_sub_range, state_q == ST_RUN, sub_q <= SUB_LO_TAIL, "pin-state count out of range")
	`ASSERT_IMP(a_pc_range, state_q == ST_RUN, pc_q <= PC_LAST, "program counter out of range")
	`ASSERT_NXT(a_end_idle, byte_done && cw.end_run, state_q == ST_IDLE, "run did not end")

endmodule

FILE: rtl/core/lcdnw_pin_dp.sv
// pin-state datapath: nibble pick, hold time scaling and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcdnw_pin_dp import lcdnw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  step_t             step,
	input  logic [TPU_W-1:0]  tpu,
	output logic              adv,
	lcdnw_pin_if.source       pins
);

	logic              valid_q;
	logic [NIB_W-1:0]  nib_q;
	logic              rs_q;
	logic              en_q;
	logic [HOLD_W-1:0] hold_q;
	logic              last_q;

	logic [US_W-1:0]   settle_us;
	logic [US_W-1:0]   extra_us;
	logic [US_W-1:0]   us;
	logic [PROD_W-1:0] prod;
	logic              lo_half;
	logic              load;

	assign adv     = !valid_q || pins.ready;
	assign load    = step.go && adv;
	assign lo_half = step.sub > SUB_HI_TAIL;

	always_comb begin
		case (step.extra)
			EXTRA_160:  extra_us = US_WAKE_2;
			EXTRA_5000: extra_us = US_WAKE_1;
			default:    extra_us = '0;
		endcase
		settle_us = step.rs ? US_DATA : US_CMD;
		case (step.sub)
			SUB_HI_TAIL: us = settle_us;
			SUB_LO_TAIL: us = settle_us + US_BYTE_END + extra_us;
			default:     us = US_STROBE;
		endcase
		prod = PROD_W'(us) * PROD_W'(tpu);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pins.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nib_q  <= lo_half ? step.byte_val[NIB_W-1:0] : step.byte_val[BYTE_W-1:NIB_W];
			rs_q   <= step.rs;
			en_q   <= (step.sub == SUB_E_HI_HI) || (step.sub == SUB_E_HI_LO);
			// saturate products past the hold field width
			hold_q <= (prod[PROD_W-1:HOLD_W] != '0) ? '1 : prod[HOLD_W-1:0];
			last_q <= step.end_run && (step.sub == SUB_LO_TAIL);
		end
	end

	assign pins.valid           = valid_q;
	assign pins.data_nibble     = nib_q;
	assign pins.register_select = rs_q;
	assign pins.enable_pin      = en_q;
	assign pins.hold_ticks      = hold_q;
	assign pins.last            = last_q;

	`ASSERT_IMP(a_last_e_low, valid_q && last_q, !en_q, "final pin state has E high")

endmodule

FILE: rtl/core/char_lcd_nibble_write_sequencer_top.sv
// top level of the character lcd 4-bit nibble write sequencer
//
// channel | dir | handshake     | payload
// req     | in  | valid / ready | mode, byte_value
// pins    | out | valid / ready | data_nibble, register_select, enable_pin, hold_ticks, last
// cfg     | in  | cfg_we        | cfg_data (ticks_per_us)
//
// one pin state per cycle unless pins.ready stalls; a byte is 6 pin states, the clear run 12,
// the initialization run 48, set by the byte program counter and 6-step state counter
// a new request is taken the cycle after the last pin state is loaded into the output register
// output register stalls the sequencer while it holds a pin state and pins.ready is low
// arst_n clears the sequencer to idle, the output valid and ticks_per_us to 3
`timescale 1ns / 1ps
module char_lcd_nibble_write_sequencer_top import lcdnw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	lcdnw_req_if.sink        req,
	lcdnw_pin_if.source      pins,
	input  logic             cfg_we,
	input  logic [TPU_W-1:0] cfg_data
);

	logic [TPU_W-1:0] tpu_q;
	logic             adv;
	step_t            step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (cfg_we) begin
			tpu_q <= cfg_data;
		end
	end

	lcdnw_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_mode  (req.mode),
		.req_byte  (req.byte_value),
		.adv       (adv),
		.step      (step)
	);

	lcdnw_pin_dp u_pin_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tpu    (tpu_q),
		.adv    (adv),
		.pins   (pins)
	);

endmodule

FILE: bench/tb_char_lcd_nibble_write_sequencer_top.sv
// testbench of the lcd nibble write sequencer: random requests checked against a pin-state predictor
`timescale 1ns / 1ps
module tb_char_lcd_nibble_write_sequencer_top import lcdnw_pkg::*; ();

	localparam int unsigned HOLD_SAT     = 524287;
	localparam int unsigned STROBE_US    = 6;
	localparam int unsigned CMD_SETTLE   = 40;
	localparam int unsigned DATA_SETTLE  = 1600;
	localparam int unsigned BYTE_END_US  = 1000;
	localparam int unsigned WAKE_LONG_US = 5000;
	localparam int unsigned WAKE_US      = 160;
	localparam logic [63:0] INIT_BYTES   = 64'h3030_3028_0180_1006;
	localparam logic [BYTE_W-1:0] CLEAR_BYTE = 8'h01;
	localparam logic [BYTE_W-1:0] HOME_BYTE  = 8'h80;

	typedef struct packed {
		logic [NIB_W-1:0]  nibble;
		logic              rs;
		logic              strobe;
		logic [HOLD_W-1:0] hold;
		logic              last;
	} pin_state_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TPU_W-1:0] cfg_data;

	lcdnw_req_if req_ch ();
	lcdnw_pin_if pin_ch ();

	char_lcd_nibble_write_sequencer_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.pins    (pin_ch),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	pin_state_t pending_pins[$];
	logic [TPU_W-1:0] tick_rate;
	bit no_idle;
	int hold_off_left;
	int fail_count;
	int n_requests;
	int n_init;
	int n_clear;
	int n_pins;
	int n_rates;

	always #5 clk = ~clk;

	function automatic logic [HOLD_W-1:0] us_to_ticks(input int unsigned us);
		int unsigned prod;
		prod = us * tick_rate;
		return (prod > HOLD_SAT) ? HOLD_W'(HOLD_SAT) : HOLD_W'(prod);
	endfunction

	// six pin states of one byte, high nibble first
	task automatic queue_byte_states(input logic [BYTE_W-1:0] b, input logic rs,
			input int unsigned extra_us, input logic final_byte);
		logic [NIB_W-1:0] nib;
		int unsigned tail;
		for (int half = 0; half < 2; half++) begin
			nib = (half == 0) ? b[7:4] : b[3:0];
			tail = rs ? DATA_SETTLE : CMD_SETTLE;
			if (half == 1)
				tail += BYTE_END_US + extra_us;
			pending_pins.push_back('{nib, rs, 1'b0, us_to_ticks(STROBE_US), 1'b0});
			pending_pins.push_back('{nib, rs, 1'b1, us_to_ticks(STROBE_US), 1'b0});
			pending_pins.push_back('{nib, rs, 1'b0, us_to_ticks(tail),
				(half == 1) && final_byte});
		end
	endtask

	task automatic queue_pin_run(input mode_t m, input logic [BYTE_W-1:0] b);
		int unsigned extra;
		case (m)
			MODE_CMD: queue_byte_states(b, 1'b0, 0, 1'b1);
			MODE_DATA: queue_byte_states(b, 1'b1, 0, 1'b1);
			MODE_INIT: begin
				n_init++;
				for (int i = 0; i < 8; i++) begin
					extra = (i == 0) ? WAKE_LONG_US : (i < 3) ? WAKE_US : 0;
					queue_byte_states(INIT_BYTES[63-8*i -: 8], 1'b0, extra, i == 7);
				end
			end
			default: begin
				n_clear++;
				queue_byte_states(CLEAR_BYTE, 1'b0, 0, 1'b0);
				queue_byte_states(HOME_BYTE, 1'b0, 0, 1'b1);
			end
		endcase
	endtask

	// offers one request and returns at the edge that accepts it, valid still high
	task automatic send_request(input mode_t m, input logic [BYTE_W-1:0] b);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 28) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.byte_value <= b;
		do @(posedge clk); while (!req_ch.ready);
		n_requests++;
		queue_pin_run(m, b);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_pins.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_tick_rate(input logic [TPU_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tick_rate = v;
		n_rates++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			pin_ch.ready <= 1'b0;
		end else if (hold_off_left > 0) begin
			pin_ch.ready <= 1'b0;
			hold_off_left--;
		end else begin
			pin_ch.ready <= no_idle || ($urandom_range(99) >= 28);
		end
	end

	always @(posedge clk) begin : pin_check
		pin_state_t want;
		if (arst_n && pin_ch.valid && pin_ch.ready) begin
			n_pins++;
			if (pending_pins.size() == 0) begin
				$error("pin state with no request pending: nibble %0h", pin_ch.data_nibble);
				fail_count++;
			end else begin
				want = pending_pins.pop_front();
				check_field("data_nibble", want.nibble, pin_ch.data_nibble);
				check_field("register_select", want.rs, pin_ch.register_select);
				check_field("enable_pin", want.strobe, pin_ch.enable_pin);
				check_field("hold_ticks", want.hold, pin_ch.hold_ticks);
				check_field("last", want.last, pin_ch.last);
			end
		end
	end

	task automatic test_basic_bytes();
		send_request(MODE_CMD, 8'h00);
		send_request(MODE_CMD, 8'hFF);
		send_request(MODE_DATA, 8'h00);
		send_request(MODE_DATA, 8'hFF);
		send_request(MODE_DATA, 8'hA5);
		send_request(MODE_CMD, 8'h5A);
		send_request(MODE_INIT, BYTE_W'($urandom));
		send_request(MODE_CLEAR, BYTE_W'($urandom));
	endtask

	// zero rate gives zero holds, top rate saturates the longest hold
	task automatic test_tick_rate_extremes();
		write_tick_rate(7'd0);
		send_request(MODE_CMD, 8'h3C);
		send_request(MODE_INIT, 8'h00);
		write_tick_rate(7'd127);
		send_request(MODE_DATA, 8'hFF);
		send_request(MODE_INIT, 8'hFF);
		send_request(MODE_CLEAR, 8'h00);
		write_tick_rate(7'd64);
		send_request(MODE_INIT, 8'h55);
		send_request(MODE_DATA, 8'h96);
		write_tick_rate(7'd1);
		send_request(MODE_CMD, 8'hC3);
		send_request(MODE_CLEAR, 8'hAA);
	endtask

	// byte_value must not matter for the init and clear runs
	task automatic test_unused_byte();
		send_request(MODE_INIT, 8'hFF);
		send_request(MODE_INIT, 8'h00);
		send_request(MODE_CLEAR, 8'hFF);
		send_request(MODE_CLEAR, 8'h00);
	endtask

	// sink holds off while requests keep coming so the input stalls
	task automatic test_output_backpressure();
		wait_idle();
		no_idle = 1'b1;
		hold_off_left = 300;
		send_request(MODE_DATA, BYTE_W'($urandom));
		send_request(MODE_CMD, BYTE_W'($urandom));
		send_request(MODE_CLEAR, BYTE_W'($urandom));
		send_request(MODE_DATA, BYTE_W'($urandom));
		while (hold_off_left > 0)
			@(negedge clk);
		no_idle = 1'b0;
		wait_idle();
	endtask

	task automatic test_random_traffic(input int n_items);
		int per_phase;
		int pick;
		mode_t m;
		per_phase = n_items / 6;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_tick_rate(TPU_W'($urandom_range(64, 1)));
				1: write_tick_rate(7'd127);
				2: write_tick_rate(7'd0);
				3: write_tick_rate(TPU_W'($urandom_range(126, 65)));
				4: write_tick_rate(7'd1);
				default: write_tick_rate(7'd64);
			endcase
			// one phase runs with no gaps on either side
			no_idle = (phase == 3);
			for (int i = 0; i < per_phase; i++) begin
				pick = $urandom_range(99);
				if (pick < 44)
					m = MODE_CMD;
				else if (pick < 88)
					m = MODE_DATA;
				else if (pick < 94)
					m = MODE_CLEAR;
				else
					m = MODE_INIT;
				send_request(m, BYTE_W'($urandom));
				if ($urandom_range(39) == 0)
					wait_idle();
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = '0;
		req_ch.byte_value = '0;
		pin_ch.ready = 1'b0;
		tick_rate = TPU_W'(3);
		no_idle = 1'b0;
		hold_off_left = 0;
		fail_count = 0;
		n_requests = 0;
		n_init = 0;
		n_clear = 0;
		n_pins = 0;
		n_rates = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_bytes();
		test_tick_rate_extremes();
		test_unused_byte();
		test_output_backpressure();
		test_random_traffic(432);

		wait_idle();
		repeat (20) @(posedge clk);
		if (pending_pins.size() != 0) begin
			$error("%0d pin states never arrived", pending_pins.size());
			fail_count++;
		end
		$display("run covered %0d requests (%0d init runs, %0d clear runs), %0d pin states",
			n_requests, n_init, n_clear, n_pins);
		$display("tick rate written %0d times incl. 0, 1, 64 and 127; %0d mismatches",
			n_rates, fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
